### rtl/core/slt_pkg.sv
// ----------------------------------------------------------------------------
// slt_pkg: shared types and constants of the sorted list table
// Table depth, word widths, operation and status codes, cell commands.
// ----------------------------------------------------------------------------
package slt_pkg;

    localparam int DEPTH   = 16;
    localparam int VALUE_W = 32;
    localparam int POS_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic [POS_W-1:0]          pos_t;
    typedef logic [CNT_W-1:0]          cnt_t;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_SEARCH = 2'd1,
        KIND_REMOVE = 2'd2,
        KIND_LIST   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        STAT_INSERTED  = 3'd0,
        STAT_FULL      = 3'd1,
        STAT_FOUND     = 3'd2,
        STAT_NOT_FOUND = 3'd3,
        STAT_REMOVED   = 3'd4,
        STAT_EMPTY     = 3'd5,
        STAT_LIST_ITEM = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_NEW,
        CELL_LEFT,
        CELL_RIGHT,
        CELL_HEAD
    } cell_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_REMOVE,
        ST_LIST
    } state_t;

    // compare flags of one cell against the operand; a free cell reads as
    // greater than anything so that an insert lands just past the last entry
    typedef struct packed {
        logic gt;
        logic ge;
        logic eq;
    } cell_flags_t;

endpackage

### rtl/core/slt_cell.sv
// ----------------------------------------------------------------------------
// slt_cell: one entry of the sorted list table
// Holds one value, compares it with the operand and takes a new value, the
// left or right neighbour's value or the head value on command.
// ----------------------------------------------------------------------------
module slt_cell (
    input  logic                 aclk,
    input  slt_pkg::cell_op_t    op,
    input  logic                 occ,
    input  slt_pkg::value_t      key,
    input  slt_pkg::value_t      left_val,
    input  slt_pkg::value_t      right_val,
    input  slt_pkg::value_t      head_val,
    output slt_pkg::value_t      entry,
    output slt_pkg::cell_flags_t flags
);
    import slt_pkg::*;

    value_t entry_reg;
    value_t entry_next;

    always_comb begin
        case (op)
            CELL_NEW:   entry_next = key;
            CELL_LEFT:  entry_next = left_val;
            CELL_RIGHT: entry_next = right_val;
            CELL_HEAD:  entry_next = head_val;
            default:    entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry    = entry_reg;
    assign flags.gt = !occ || (entry_reg > key);
    assign flags.ge = !occ || (entry_reg >= key);
    assign flags.eq = occ && (entry_reg == key);

endmodule

### rtl/core/sorted_list_table_top.sv
// ----------------------------------------------------------------------------
// sorted_list_table_top: ascending sorted table of signed words
// Insert, search, remove-all-matches and list over a row of compare cells.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                                        | tuser   | tlast
//  s_       | in  | value[31:0]                                  | kind    | -
//  m_       | out | value, position, removed_count, entry_count  | status  | last
//
//  Accept registers the operand; insert and search then finish in the execute state.
//  Remove steps the cells once per deleted match and once more to report.
//  List emits one word per cycle while the output is free, by rotating the
//  occupied cells through cell 0. A stalled result holds the block.
//  Synchronous active-low reset empties the table; cell contents keep.
module sorted_list_table_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic [1:0]  s_tuser,   // [1:0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [31:0] result_value, [35:32] position,
                                   // [40:36] removed_count, [45:41] entry_count
    output logic [2:0]  m_tuser,   // [2:0] status
    output logic        m_tlast    // last
);
    import slt_pkg::*;

    state_t  state_reg, state_next;
    kind_t   kind_reg;
    value_t  value_reg;
    cnt_t    count_reg, count_next;
    cnt_t    rem_reg, rem_next;
    pos_t    idx_reg, idx_next;

    logic    m_valid_reg;
    status_t m_status_reg, e_status;
    value_t  m_value_reg, e_value;
    pos_t    m_pos_reg, e_pos;
    cnt_t    m_removed_reg, e_removed;
    cnt_t    m_entries_reg;
    logic    m_last_reg, e_last;

    logic emit, out_free, s_accept;
    logic do_insert, do_remove, do_list;

    value_t      entries [DEPTH];
    cell_flags_t flags   [DEPTH];
    cell_op_t    ops     [DEPTH];
    logic [DEPTH-1:0] eq_vec;
    logic [DEPTH-1:0] first_vec;
    logic any_eq;
    pos_t first_pos;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // ---- cell row ----
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic   gt_prev;
        logic   ge_prev;
        value_t left_v;
        value_t right_v;

        if (i == 0) begin : g_head
            assign gt_prev = 1'b0;
            assign ge_prev = 1'b0;
            assign left_v  = entries[i];
        end else begin : g_body
            assign gt_prev = flags[i-1].gt;
            assign ge_prev = flags[i-1].ge;
            assign left_v  = entries[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign right_v = entries[i];
        end else begin : g_inner
            assign right_v = entries[i+1];
        end

        assign eq_vec[i]    = flags[i].eq;
        assign first_vec[i] = flags[i].eq && !ge_prev;

        always_comb begin
            ops[i] = CELL_HOLD;
            if (do_insert) begin
                if (gt_prev) begin
                    ops[i] = CELL_LEFT;
                end else if (flags[i].gt) begin
                    ops[i] = CELL_NEW;
                end
            end else if (do_remove) begin
                if (flags[i].ge) begin
                    ops[i] = CELL_RIGHT;
                end
            end else if (do_list) begin
                if (CNT_W'(i + 1) == count_reg) begin
                    ops[i] = CELL_HEAD;
                end else if (CNT_W'(i + 1) < count_reg) begin
                    ops[i] = CELL_RIGHT;
                end
            end
        end

        slt_cell u_cell (
            .aclk      (aclk),
            .op        (ops[i]),
            .occ       (CNT_W'(i) < count_reg),
            .key       (value_reg),
            .left_val  (left_v),
            .right_val (right_v),
            .head_val  (entries[0]),
            .entry     (entries[i]),
            .flags     (flags[i])
        );
    end

    assign any_eq = |eq_vec;

    // first match is one-hot in a sorted row: merge its index
    always_comb begin
        first_pos = '0;
        for (int k = 0; k < DEPTH; k++) begin
            if (first_vec[k]) begin
                first_pos = first_pos | POS_W'(k);
            end
        end
    end

    // ---- control ----
    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        rem_next   = rem_reg;
        idx_next   = idx_reg;
        do_insert  = 1'b0;
        do_remove  = 1'b0;
        do_list    = 1'b0;
        emit       = 1'b0;
        e_status   = STAT_INSERTED;
        e_value    = '0;
        e_pos      = '0;
        e_removed  = '0;
        e_last     = 1'b1;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                unique case (kind_reg)
                    KIND_INSERT: begin
                        if (out_free) begin
                            emit       = 1'b1;
                            state_next = ST_IDLE;
                            if (count_reg == CNT_W'(DEPTH)) begin
                                e_status = STAT_FULL;
                            end else begin
                                do_insert  = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                    end
                    KIND_SEARCH: begin
                        if (out_free) begin
                            emit       = 1'b1;
                            state_next = ST_IDLE;
                            if (any_eq) begin
                                e_status = STAT_FOUND;
                                e_value  = value_reg;
                                e_pos    = first_pos;
                            end else begin
                                e_status = STAT_NOT_FOUND;
                            end
                        end
                    end
                    KIND_REMOVE, KIND_LIST: begin
                        if (count_reg == '0) begin
                            if (out_free) begin
                                emit       = 1'b1;
                                e_status   = STAT_EMPTY;
                                state_next = ST_IDLE;
                            end
                        end else if (kind_reg == KIND_REMOVE) begin
                            rem_next   = '0;
                            state_next = ST_REMOVE;
                        end else begin
                            idx_next   = '0;
                            state_next = ST_LIST;
                        end
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_REMOVE: begin
                // drop one match per cycle, report once none is left
                if (any_eq) begin
                    do_remove  = 1'b1;
                    count_next = count_reg - 1'b1;
                    rem_next   = rem_reg + 1'b1;
                end else if (out_free) begin
                    emit       = 1'b1;
                    e_status   = STAT_REMOVED;
                    e_removed  = rem_reg;
                    state_next = ST_IDLE;
                end
            end
            ST_LIST: begin
                if (out_free) begin
                    do_list  = 1'b1;
                    emit     = 1'b1;
                    e_status = STAT_LIST_ITEM;
                    e_value  = entries[0];
                    e_pos    = idx_reg;
                    e_last   = ({1'b0, idx_reg} + 1'b1) == count_reg;
                    idx_next = idx_reg + 1'b1;
                    if (e_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= emit || (m_valid_reg && !m_tready);
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        idx_reg <= idx_next;
        if (s_accept) begin
            kind_reg  <= kind_t'(s_tuser);
            value_reg <= value_t'(s_tdata);
        end
        if (emit) begin
            m_status_reg  <= e_status;
            m_value_reg   <= e_value;
            m_pos_reg     <= e_pos;
            m_removed_reg <= e_removed;
            m_entries_reg <= count_next;
            m_last_reg    <= e_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_entries_reg, m_removed_reg, m_pos_reg, m_value_reg};
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

endmodule
